// ----- src/http_response_header_parser_top_defines.svh -----
// ----------------------------------------------------------------------------
// HTTP response header parser - assertion macros
// Shared macros for the concurrent checks of the parser.
// ----------------------------------------------------------------------------
`ifndef HTTP_RESPONSE_HEADER_PARSER_TOP_DEFINES_SVH
`define HTTP_RESPONSE_HEADER_PARSER_TOP_DEFINES_SVH

// Plain property, sampled on clk_i, off while in reset.
`define HRHP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication.
`define HRHP_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HRHP_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/hrhp_pkg.sv -----
// ----------------------------------------------------------------------------
// HTTP response header parser - package
// Result types, byte constants and the per-byte header matching functions.
// ----------------------------------------------------------------------------
package hrhp_pkg;

  typedef enum logic [1:0] {
    KIND_TYPE    = 2'd0,
    KIND_VERDICT = 2'd1,
    KIND_BODY    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_NO_END  = 2'd1,
    ERR_STATUS  = 2'd2,
    ERR_NO_TYPE = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_BODY   = 3'b010,
    PH_DROP   = 3'b100
  } phase_e;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam int unsigned StatusLen = 15;
  localparam int unsigned TypeLen   = 14;

  localparam logic [4:0] STATUS_PREFIX_LEN = 5'd9;
  localparam logic [4:0] STATUS_FULL_LEN   = 5'd15;
  localparam logic [4:0] TYPE_PREFIX_LEN   = 5'd14;
  localparam logic [4:0] POS_MAX           = 5'd31;

  localparam logic [8*StatusLen-1:0] STATUS_TEXT = "HTTP/1.1 200 OK";
  localparam logic [8*TypeLen-1:0]   TYPE_TEXT   = "Content-Type: ";

  // Per-line matching state plus the two message-level flags it updates.
  typedef struct packed {
    logic [4:0] pos;
    logic       st_match;
    logic       ty_match;
    logic       in_val;
    logic       status_bad;
    logic       ty_nonempty;
  } line_t;

  typedef struct packed {
    line_t s;
    logic  emit;
    logic  start;
  } cb_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       start;
    err_e       code;
    logic       last;
  } result_t;

  // Results caused by one item: up to two.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } bundle_t;

  localparam line_t LINE_RESET = '{
    pos: 5'd0, st_match: 1'b1, ty_match: 1'b1, in_val: 1'b0,
    status_bad: 1'b0, ty_nonempty: 1'b0
  };

  function automatic logic [7:0] status_char(input logic [4:0] p);
    logic [7:0] c;
    c = 8'h00;
    if (p < STATUS_FULL_LEN) begin
      c = STATUS_TEXT[8*(StatusLen-1-int'(p)) +: 8];
    end
    return c;
  endfunction

  function automatic logic [7:0] type_char(input logic [4:0] p);
    logic [7:0] c;
    c = 8'h00;
    if (p < TYPE_PREFIX_LEN) begin
      c = TYPE_TEXT[8*(TypeLen-1-int'(p)) +: 8];
    end
    return c;
  endfunction

  // CR LF CR LF tracker; returns 4 on the header end.
  function automatic logic [2:0] next_end(input logic [1:0] c, input logic [7:0] b);
    logic [2:0] n;
    n = 3'd0;
    if (b == CH_CR) begin
      n = (c == 2'd2) ? 3'd3 : 3'd1;
    end else if (b == CH_LF && (c == 2'd1 || c == 2'd3)) begin
      n = {1'b0, c} + 3'd1;
    end
    return n;
  endfunction

  // One byte of line content.
  function automatic cb_t content_byte(input line_t s, input logic [7:0] b);
    cb_t r;
    r.s     = s;
    r.emit  = s.in_val;
    r.start = !s.ty_nonempty;
    if (s.st_match) begin
      if (!(s.pos < STATUS_FULL_LEN && b == status_char(s.pos))) begin
        if (s.pos >= STATUS_PREFIX_LEN) begin
          r.s.status_bad = 1'b1;
        end
        r.s.st_match = 1'b0;
      end
    end
    if (s.ty_match) begin
      if (s.pos < TYPE_PREFIX_LEN && b == type_char(s.pos)) begin
        if (s.pos == TYPE_PREFIX_LEN - 5'd1) begin
          r.s.in_val      = 1'b1;
          r.s.ty_nonempty = 1'b0;
          r.s.ty_match    = 1'b0;
        end
      end else begin
        r.s.ty_match = 1'b0;
      end
    end
    if (s.in_val) begin
      r.s.ty_nonempty = 1'b1;
    end
    if (s.pos < POS_MAX) begin
      r.s.pos = s.pos + 5'd1;
    end
    return r;
  endfunction

  // CR LF seen: judge a short status line, then start a fresh line.
  function automatic line_t line_end(input line_t s);
    line_t r;
    r = LINE_RESET;
    r.status_bad  = s.status_bad;
    r.ty_nonempty = s.ty_nonempty;
    if (s.st_match && s.pos >= STATUS_PREFIX_LEN && s.pos < STATUS_FULL_LEN) begin
      r.status_bad = 1'b1;
    end
    return r;
  endfunction

  function automatic result_t type_result(input logic [7:0] b, input logic start);
    result_t r;
    r.kind  = KIND_TYPE;
    r.data  = b;
    r.start = start;
    r.code  = ERR_NONE;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage

// ----- src/hrhp_front.sv -----
// ----------------------------------------------------------------------------
// HTTP response header parser - front end
// Accepts bytes, tracks header/body/drop phase and builds the results of
// each byte as one bundle for the queue.
// ----------------------------------------------------------------------------
module hrhp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              end_of_message_i,
  input  logic              q_ready_i,
  output logic              push_o,
  output hrhp_pkg::bundle_t bundle_o
);

  hrhp_pkg::phase_e phase_q, phase_d;
  logic [1:0]       end_q, end_d;
  hrhp_pkg::line_t  line_q, line_d;
  logic             held_q, held_d;

  logic             accept;
  logic [2:0]       nc;
  logic             header_end;
  hrhp_pkg::cb_t    cb_cr, cb_after_cr, cb_b;
  hrhp_pkg::line_t  ls;
  logic             held_n;
  logic             e_a, e_b;
  hrhp_pkg::result_t res_a, res_b, verdict;
  hrhp_pkg::err_e   code;
  hrhp_pkg::bundle_t bundle;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;

  assign nc          = hrhp_pkg::next_end(end_q, data_byte_i);
  assign header_end  = (nc == 3'd4);
  assign cb_cr       = hrhp_pkg::content_byte(line_q, hrhp_pkg::CH_CR);
  assign cb_after_cr = hrhp_pkg::content_byte(cb_cr.s, data_byte_i);
  assign cb_b        = hrhp_pkg::content_byte(line_q, data_byte_i);

  // Held CR: resolved by the byte that follows it.
  always_comb begin
    ls     = line_q;
    held_n = held_q;
    e_a    = 1'b0;
    e_b    = 1'b0;
    res_a  = hrhp_pkg::type_result(hrhp_pkg::CH_CR, cb_cr.start);
    res_b  = hrhp_pkg::type_result(data_byte_i, cb_b.start);
    if (held_q) begin
      held_n = 1'b0;
      if (data_byte_i == hrhp_pkg::CH_LF) begin
        ls = hrhp_pkg::line_end(line_q);
      end else if (data_byte_i == hrhp_pkg::CH_CR) begin
        ls     = cb_cr.s;
        held_n = 1'b1;
        e_a    = cb_cr.emit;
      end else begin
        ls    = cb_after_cr.s;
        e_a   = cb_cr.emit;
        e_b   = cb_after_cr.emit;
        res_b = hrhp_pkg::type_result(data_byte_i, cb_after_cr.start);
      end
    end else if (data_byte_i == hrhp_pkg::CH_CR) begin
      held_n = 1'b1;
    end else begin
      ls  = cb_b.s;
      e_b = cb_b.emit;
    end
  end

  always_comb begin
    if (ls.status_bad) begin
      code = hrhp_pkg::ERR_STATUS;
    end else if (ls.ty_nonempty) begin
      code = hrhp_pkg::ERR_NONE;
    end else begin
      code = hrhp_pkg::ERR_NO_TYPE;
    end
  end

  always_comb begin
    phase_d = phase_q;
    end_d   = end_q;
    line_d  = line_q;
    held_d  = held_q;
    verdict = '{kind: hrhp_pkg::KIND_VERDICT, data: 8'h00, start: 1'b0,
                code: hrhp_pkg::ERR_NO_END, last: 1'b1};
    bundle  = '{cnt: 2'd0, r0: res_a, r1: res_b};

    unique case (phase_q)
      hrhp_pkg::PH_HEADER: begin
        end_d  = header_end ? 2'd0 : nc[1:0];
        line_d = ls;
        held_d = held_n;
        if (header_end) begin
          verdict.code = code;
          verdict.last = (code != hrhp_pkg::ERR_NONE) || end_of_message_i;
          bundle.cnt   = 2'd1;
          bundle.r0    = verdict;
          phase_d      = (code == hrhp_pkg::ERR_NONE) ? hrhp_pkg::PH_BODY
                                                       : hrhp_pkg::PH_DROP;
        end else if (end_of_message_i) begin
          bundle.cnt = 2'd1;
          bundle.r0  = verdict;
        end else begin
          bundle.cnt = {1'b0, e_a} + {1'b0, e_b};
          bundle.r0  = e_a ? res_a : res_b;
        end
      end
      hrhp_pkg::PH_BODY: begin
        bundle.cnt = 2'd1;
        bundle.r0  = '{kind: hrhp_pkg::KIND_BODY, data: data_byte_i, start: 1'b0,
                       code: hrhp_pkg::ERR_NONE, last: end_of_message_i};
      end
      default: begin
        // drop phase: nothing out until the message ends
      end
    endcase

    if (end_of_message_i) begin
      phase_d = hrhp_pkg::PH_HEADER;
      end_d   = 2'd0;
      line_d  = hrhp_pkg::LINE_RESET;
      held_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hrhp_pkg::PH_HEADER;
      end_q   <= 2'd0;
      line_q  <= hrhp_pkg::LINE_RESET;
      held_q  <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      end_q   <= end_d;
      line_q  <= line_d;
      held_q  <= held_d;
    end
  end

  assign push_o   = accept && (bundle.cnt != 2'd0);
  assign bundle_o = bundle;

endmodule

// ----- src/hrhp_queue.sv -----
// ----------------------------------------------------------------------------
// HTTP response header parser - bundle queue
// Short FIFO of result bundles between the front and back ends.
// ----------------------------------------------------------------------------
module hrhp_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hrhp_pkg::bundle_t bundle_i,
  output logic              ready_o,
  output logic              valid_o,
  output hrhp_pkg::bundle_t head_o,
  input  logic              pop_i
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  hrhp_pkg::bundle_t mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign ready_o = (cnt_q != CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= bundle_i;
    end
  end

endmodule

// ----- src/hrhp_back.sv -----
// ----------------------------------------------------------------------------
// HTTP response header parser - back end
// Unpacks queued bundles into single results, one per cycle while the receiver
// is ready, through an output register.
// ----------------------------------------------------------------------------
module hrhp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  hrhp_pkg::bundle_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hrhp_pkg::result_t res_o
);

  logic              out_valid_q, out_valid_d;
  logic              idx_q, idx_d;
  hrhp_pkg::result_t res_q;
  hrhp_pkg::result_t sel;
  logic              load;

  assign load = q_valid_i && (!out_valid_q || out_ready_i);
  assign sel  = idx_q ? head_i.r1 : head_i.r0;

  always_comb begin
    out_valid_d = out_valid_q;
    idx_d       = idx_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = 1'b1;
      if (idx_q || head_i.cnt == 2'd1) begin
        pop_o = 1'b1;
        idx_d = 1'b0;
      end else begin
        idx_d = 1'b1;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= sel;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// ----- src/http_response_header_parser_top.sv -----
// ----------------------------------------------------------------------------
// HTTP response header parser - top level
// Byte-stream HTTP response header checker with content-type extraction.
// ----------------------------------------------------------------------------
// Takes one response byte per cycle while the bundle queue has room. Each byte
// yields zero, one or two results; the back end delivers one result per cycle
// from its output register while the receiver takes them, so a byte with two
// results (a content-type byte after a held CR) briefly backs up the input. Each
// bundle passes the queue and then the output register. Throughput is set by
// the single-result-per-cycle back end and the QueueDepth-entry bundle queue.
module http_response_header_parser_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_message_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic       type_start_o,
  output logic [1:0] error_code_o,
  output logic       last_o
);

  logic              q_ready, q_valid, push, pop;
  hrhp_pkg::bundle_t bundle, head;
  hrhp_pkg::result_t res;

  hrhp_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .data_byte_i,
    .end_of_message_i,
    .q_ready_i (q_ready),
    .push_o    (push),
    .bundle_o  (bundle)
  );

  hrhp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i   (push),
    .bundle_i (bundle),
    .ready_o  (q_ready),
    .valid_o  (q_valid),
    .head_o   (head),
    .pop_i    (pop)
  );

  hrhp_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i (q_valid),
    .head_i    (head),
    .pop_o     (pop),
    .out_valid_o,
    .out_ready_i,
    .res_o     (res)
  );

  assign kind_o       = res.kind;
  assign out_byte_o   = res.data;
  assign type_start_o = res.start;
  assign error_code_o = res.code;
  assign last_o       = res.last;

endmodule

// ----- src/hrhp_checker.sv -----
// ----------------------------------------------------------------------------
// HTTP response header parser - port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "http_response_header_parser_top_defines.svh"

module hrhp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] data_byte_i,
  input logic       end_of_message_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] kind_o,
  input logic [7:0] out_byte_o,
  input logic       type_start_o,
  input logic [1:0] error_code_o,
  input logic       last_o
);

  logic        in_stall;
  logic        out_stall;
  logic [8:0]  in_item;
  logic [13:0] out_item;
  logic        code_set;
  logic        err_verdict;
  logic        non_verdict;
  logic        start_ok;

  assign in_stall    = in_valid_i && !in_ready_o;
  assign out_stall   = out_valid_o && !out_ready_i;
  assign in_item     = {data_byte_i, end_of_message_i};
  assign out_item    = {kind_o, out_byte_o, type_start_o, error_code_o, last_o};
  assign code_set    = (error_code_o != hrhp_pkg::ERR_NONE);
  assign err_verdict = out_valid_o && (kind_o == hrhp_pkg::KIND_VERDICT) && code_set;
  assign non_verdict = out_valid_o && (kind_o != hrhp_pkg::KIND_VERDICT);
  assign start_ok    = (kind_o == hrhp_pkg::KIND_TYPE) && !last_o;

  `HRHP_ASSERT_NXT(a_in_hold, in_stall, in_valid_i && $stable(in_item), "input item not held")

  `HRHP_ASSERT_NXT(a_out_hold, out_stall, out_valid_o && $stable(out_item), "result not held")

  `HRHP_ASSERT_IMP(a_err_last, err_verdict, last_o, "error verdict without last")

  `HRHP_ASSERT_IMP(a_start_type, out_valid_o && type_start_o, start_ok, "stray start mark")

  `HRHP_ASSERT_IMP(a_code_verdict, non_verdict, !code_set, "error code on non-verdict")

endmodule

bind http_response_header_parser_top hrhp_checker u_hrhp_checker (.*);

// ----- tb/http_response_header_parser_top_tb.sv -----
// ----------------------------------------------------------------------------
// HTTP response header parser - testbench
// Sends whole responses byte by byte through the valid/ready input, mirrors
// the header parsing in a behavioral predictor and checks every result field
// in order. A short table of hand-picked messages runs first, then random
// responses: mostly well-formed headers with mutated status and content-type
// lines, plus raw noise and truncated messages.
// ----------------------------------------------------------------------------
module http_response_header_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomItems = 750;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_SPARSE,
    SINK_BEAT
  } sink_mode_e;

  typedef struct {
    string          text;
    int             lone;   // single raw byte instead of text when >= 0
    bit             eom;
    bit             typed;
    hrhp_pkg::err_e code;
  } dir_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] data_byte_i;
  logic       end_of_message_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [1:0] kind_o;
  logic [7:0] out_byte_o;
  logic       type_start_o;
  logic [1:0] error_code_o;
  logic       last_o;

  // Parser mirror
  hrhp_pkg::phase_e hdr_phase;
  logic [1:0]       crlf_run;
  logic [4:0]       line_pos;
  bit               status_track;
  bit               type_track;
  bit               in_value;
  bit               cr_held;
  bit               status_bad;
  bit               value_nonempty;

  string      status_line = "HTTP/1.1 200 OK";
  string      type_prefix = "Content-Type: ";

  hrhp_pkg::result_t step_q[$];
  hrhp_pkg::result_t expected_q[$];
  logic [7:0]        msg_bytes[$];

  int         burst_left;
  int         bytes_sent;
  int         msgs_sent;
  int         results_checked;
  int         body_seen;
  int         value_seen;
  int         verdict_seen[4];
  int         mismatches;

  dir_row_t dir_rows [0:6] = '{
    // header end on the final byte, then single bytes with no header end
    '{"\015\012\015\012", -1, 1'b1, 1'b1, hrhp_pkg::ERR_NO_TYPE},
    '{"", 0, 1'b1, 1'b1, hrhp_pkg::ERR_NO_END},
    '{"", 255, 1'b1, 1'b1, hrhp_pkg::ERR_NO_END},
    // short status line
    '{"HTTP/1.1 2\015\012\015\012", -1, 1'b0, 1'b1, hrhp_pkg::ERR_STATUS},
    // dropped byte, then a content-type value with held CRs and its body
    '{"\377", -1, 1'b1, 1'b0, hrhp_pkg::ERR_NONE},
    '{"Content-Type: a\015b\015\015\012\015\012", -1, 1'b0, 1'b0, hrhp_pkg::ERR_NONE},
    '{"\200\377", -1, 1'b1, 1'b0, hrhp_pkg::ERR_NONE}
  };

  http_response_header_parser_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .out_byte_o       (out_byte_o),
    .type_start_o     (type_start_o),
    .error_code_o     (error_code_o),
    .last_o           (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("timeout: %0d results still outstanding", expected_q.size());
    $display("FAILURE");
    $finish;
  end

  function automatic hrhp_pkg::result_t mk_result(input hrhp_pkg::kind_e k,
                                                   input logic [7:0] d, input logic s,
                                                   input hrhp_pkg::err_e c, input logic l);
    hrhp_pkg::result_t r;
    r.kind  = k;
    r.data  = d;
    r.start = s;
    r.code  = c;
    r.last  = l;
    return r;
  endfunction

  function automatic void clear_line();
    line_pos     = 5'd0;
    status_track = 1'b1;
    type_track   = 1'b1;
    in_value     = 1'b0;
    cr_held      = 1'b0;
  endfunction

  function automatic void reset_parser();
    hdr_phase      = hrhp_pkg::PH_HEADER;
    crlf_run       = 2'd0;
    status_bad     = 1'b0;
    value_nonempty = 1'b0;
    clear_line();
  endfunction

  // A line is closed by CR LF; a status prefix that stopped short is bad.
  function automatic void close_line();
    if (status_track && line_pos >= 5'd9 && line_pos < 5'd15) status_bad = 1'b1;
    clear_line();
  endfunction

  function automatic void take_char(input logic [7:0] b);
    bit was_value;
    was_value = in_value;
    if (status_track) begin
      if (!(line_pos < 5'd15 && b == 8'(status_line[line_pos]))) begin
        if (line_pos >= 5'd9) status_bad = 1'b1;
        status_track = 1'b0;
      end
    end
    if (type_track) begin
      if (line_pos < 5'd14 && b == 8'(type_prefix[line_pos])) begin
        if (line_pos == 5'd13) begin
          in_value       = 1'b1;
          value_nonempty = 1'b0;
          type_track     = 1'b0;
        end
      end else begin
        type_track = 1'b0;
      end
    end
    if (was_value) begin
      step_q.push_back(mk_result(hrhp_pkg::KIND_TYPE, b, !value_nonempty,
                                 hrhp_pkg::ERR_NONE, 1'b0));
      value_nonempty = 1'b1;
    end
    if (line_pos != 5'd31) line_pos = line_pos + 5'd1;
  endfunction

  // Results caused by one accepted byte land in step_q.
  function automatic void parse_byte(input logic [7:0] b, input logic eom);
    logic [2:0]     nxt;
    bit             hdr_end;
    hrhp_pkg::err_e code;
    step_q.delete();
    if (hdr_phase == hrhp_pkg::PH_BODY) begin
      step_q.push_back(mk_result(hrhp_pkg::KIND_BODY, b, 1'b0, hrhp_pkg::ERR_NONE, eom));
    end else if (hdr_phase == hrhp_pkg::PH_HEADER) begin
      nxt = 3'd0;
      if (b == hrhp_pkg::CH_CR) begin
        nxt = (crlf_run == 2'd2) ? 3'd3 : 3'd1;
      end else if (b == hrhp_pkg::CH_LF && (crlf_run == 2'd1 || crlf_run == 2'd3)) begin
        nxt = {1'b0, crlf_run} + 3'd1;
      end
      hdr_end  = (nxt == 3'd4);
      crlf_run = hdr_end ? 2'd0 : nxt[1:0];
      if (cr_held) begin
        cr_held = 1'b0;
        if (b == hrhp_pkg::CH_LF) begin
          close_line();
        end else begin
          // the held CR turns out to be line content
          take_char(hrhp_pkg::CH_CR);
          if (b == hrhp_pkg::CH_CR) cr_held = 1'b1;
          else take_char(b);
        end
      end else if (b == hrhp_pkg::CH_CR) begin
        cr_held = 1'b1;
      end else begin
        take_char(b);
      end
      if (hdr_end) begin
        code = status_bad ? hrhp_pkg::ERR_STATUS
                          : (value_nonempty ? hrhp_pkg::ERR_NONE : hrhp_pkg::ERR_NO_TYPE);
        step_q.delete();
        step_q.push_back(mk_result(hrhp_pkg::KIND_VERDICT, 8'h00, 1'b0, code,
                                   (code != hrhp_pkg::ERR_NONE) || eom));
        hdr_phase = (code == hrhp_pkg::ERR_NONE) ? hrhp_pkg::PH_BODY : hrhp_pkg::PH_DROP;
      end else if (eom) begin
        step_q.delete();
        step_q.push_back(mk_result(hrhp_pkg::KIND_VERDICT, 8'h00, 1'b0,
                                   hrhp_pkg::ERR_NO_END, 1'b1));
      end
    end
    if (eom) reset_parser();
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    mismatches++;
    $display("[%0t] mismatch: %s, expected %0d, got %0d", $realtime, what, want, got);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eom, input bit keep);
    in_valid_i       <= 1'b1;
    data_byte_i      <= b;
    end_of_message_i <= eom;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
    parse_byte(b, eom);
    if (keep) foreach (step_q[k]) expected_q.push_back(step_q[k]);
  endtask

  task automatic send_message(input bit eom_at_end, input bit keep);
    int gap;
    foreach (msg_bytes[i]) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
        gap = $urandom_range(1, 6);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left--;
      send_byte(msg_bytes[i], eom_at_end && (i == msg_bytes.size() - 1), keep);
    end
  endtask

  // Hold the input idle until every outstanding result is out.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) msg_bytes.push_back(8'(s[i]));
  endfunction

  function automatic void add_crlf();
    msg_bytes.push_back(hrhp_pkg::CH_CR);
    msg_bytes.push_back(hrhp_pkg::CH_LF);
  endfunction

  function automatic logic [7:0] printable();
    return 8'($urandom_range(32, 126));
  endfunction

  function automatic logic [7:0] value_char();
    int sel;
    sel = $urandom_range(7);
    if (sel == 0) return hrhp_pkg::CH_CR;
    if (sel == 1) return 8'($urandom_range(255));
    return printable();
  endfunction

  function automatic logic [7:0] noise_char();
    int sel;
    sel = $urandom_range(5);
    if (sel == 0) return hrhp_pkg::CH_CR;
    if (sel == 1) return hrhp_pkg::CH_LF;
    return 8'($urandom_range(255));
  endfunction

  function automatic void build_message();
    int n_lines;
    int sel;
    int start;
    int len;
    msg_bytes.delete();
    if ($urandom_range(99) < 15) begin
      len = $urandom_range(1, 12);
      repeat (len) msg_bytes.push_back(noise_char());
      return;
    end
    if ($urandom_range(99) < 70) begin
      start = msg_bytes.size();
      add_text(status_line);
      sel = $urandom_range(9);
      if (sel == 0) begin
        len = $urandom_range(1, 9);
        repeat (len) void'(msg_bytes.pop_back());
      end else if (sel == 1) begin
        msg_bytes[start + $urandom_range(14)] = printable();
      end else if (sel == 2) begin
        add_text(" x");
      end
      add_crlf();
    end
    n_lines = $urandom_range(3);
    repeat (n_lines) begin
      sel = $urandom_range(9);
      if (sel < 6) begin
        start = msg_bytes.size();
        add_text(type_prefix);
        if (sel == 5) msg_bytes[start + $urandom_range(13)] = printable();
        len = ($urandom_range(15) == 0) ? $urandom_range(18, 30) : $urandom_range(0, 5);
        repeat (len) msg_bytes.push_back(value_char());
      end else begin
        len = ($urandom_range(7) == 0) ? $urandom_range(30, 45) : $urandom_range(0, 10);
        repeat (len) msg_bytes.push_back(printable());
      end
      add_crlf();
    end
    add_crlf();
    len = $urandom_range(0, 6);
    repeat (len) msg_bytes.push_back(8'($urandom_range(255)));
    // occasionally cut the response short
    if ($urandom_range(9) == 0) begin
      len = $urandom_range(1, msg_bytes.size());
      while (msg_bytes.size() > len) void'(msg_bytes.pop_back());
    end
  endfunction

  // Receiver: switches between stall patterns at random.
  initial begin
    int         stretch;
    int         tick;
    sink_mode_e mode;
    out_ready_i = 1'b0;
    stretch     = 0;
    tick        = 0;
    mode        = SINK_OPEN;
    forever begin
      @(posedge clk_i);
      if (stretch == 0) begin
        mode    = sink_mode_e'($urandom_range(3));
        stretch = $urandom_range(10, 80);
      end
      stretch--;
      tick++;
      case (mode)
        SINK_OPEN:   out_ready_i <= 1'b1;
        SINK_COIN:   out_ready_i <= 1'($urandom_range(1));
        SINK_SPARSE: out_ready_i <= ($urandom_range(3) == 0);
        default:     out_ready_i <= (tick % 5 != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    hrhp_pkg::result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing expected, kind", -1, kind_o);
      end else begin
        want = expected_q.pop_front();
        results_checked++;
        case (want.kind)
          hrhp_pkg::KIND_VERDICT: verdict_seen[want.code]++;
          hrhp_pkg::KIND_BODY:    body_seen++;
          default:                value_seen++;
        endcase
        if (kind_o !== want.kind)         report_mismatch("kind", want.kind, kind_o);
        if (out_byte_o !== want.data)     report_mismatch("out_byte", want.data, out_byte_o);
        if (type_start_o !== want.start)  report_mismatch("type_start", want.start, type_start_o);
        if (error_code_o !== want.code)   report_mismatch("error_code", want.code, error_code_o);
        if (last_o !== want.last)         report_mismatch("last", want.last, last_o);
      end
    end
  end

  initial begin
    int random_start;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    data_byte_i      = 8'h00;
    end_of_message_i = 1'b0;
    burst_left       = 0;
    reset_parser();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      msg_bytes.delete();
      if (dir_rows[r].lone >= 0) msg_bytes.push_back(8'(dir_rows[r].lone));
      else add_text(dir_rows[r].text);
      send_message(dir_rows[r].eom, !dir_rows[r].typed);
      if (dir_rows[r].typed) begin
        expected_q.push_back(mk_result(hrhp_pkg::KIND_VERDICT, 8'h00, 1'b0,
                                       dir_rows[r].code, 1'b1));
      end
    end
    drain();

    random_start = bytes_sent;
    while (bytes_sent - random_start < RandomItems) begin
      build_message();
      send_message(1'b1, 1'b1);
      msgs_sent++;
      if (msgs_sent % 8 == 0) drain();
    end

    drain();
    repeat (16) @(posedge clk_i);
    if (expected_q.size() != 0) report_mismatch("results never delivered", expected_q.size(), 0);

    $display("Sent %0d bytes in %0d random responses plus %0d directed ones",
             bytes_sent, msgs_sent, $size(dir_rows));
    $display("  checked %0d results: %0d content-type bytes, %0d body bytes, %0d/%0d/%0d/%0d %s",
             results_checked, value_seen, body_seen, verdict_seen[0], verdict_seen[1],
             verdict_seen[2], verdict_seen[3], "verdicts ok/no-end/status/no-type");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/hrhp_pkg.sv
src/hrhp_front.sv
src/hrhp_queue.sv
src/hrhp_back.sv
src/http_response_header_parser_top.sv
src/hrhp_checker.sv
tb/http_response_header_parser_top_tb.sv
